>>> hw/rtl/egbp_pkg.sv
package egbp_pkg;

  // Action codes carried on in_action
  typedef enum logic [2:0] {
    ACT_BITS  = 3'd0,
    ACT_UE    = 3'd1,
    ACT_SE    = 3'd2,
    ACT_BYTES = 3'd3,
    ACT_ALIGN = 3'd4
  } egbp_action_t;

  // Register word index (paddr[2])
  localparam logic REG_BIG_ENDIAN = 1'b0;

  localparam int unsigned ACC_W = 72;  // partial byte plus 64 stream bits
  localparam int unsigned CNT_W = 7;   // bit count held in the accumulator, up to 71

  // Controller -> datapath
  typedef struct packed {
    logic load;
    logic norm_step;
    logic build;
    logic emit;
    logic commit;
    logic err_emit;
  } egbp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic err;
    logic is_code;
    logic norm_done;
    logic ge8;
    logic slot_free;
  } egbp_status_t;

endpackage

>>> hw/rtl/egbp_ctrl.sv
module egbp_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  egbp_pkg::egbp_status_t st,
  output egbp_pkg::egbp_cmd_t   cmd
);
  import egbp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_NORM,
    S_BUILD,
    S_EMIT,
    S_ERR
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (st.err) begin
          state_nxt = S_ERR;
        end else if (st.is_code) begin
          state_nxt = S_NORM;
        end else begin
          state_nxt = S_BUILD;
        end
      end
      S_NORM: begin
        if (st.norm_done) begin
          state_nxt = S_BUILD;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      S_BUILD: begin
        cmd.build = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (st.ge8) begin
          cmd.emit = st.slot_free;
        end else begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_ERR: begin
        if (st.slot_free) begin
          cmd.err_emit = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

`ifndef NO_ASSERTIONS
  a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_DECODE))
    else $error("load did not move to decode");
  a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> st.ge8 && st.slot_free)
    else $error("word emitted without a full byte or a free slot");
  a_commit_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit || cmd.err_emit) |=> in_ready)
    else $error("item end did not return to idle");
`endif

endmodule

>>> hw/rtl/egbp_dp.sv
module egbp_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  egbp_pkg::egbp_cmd_t    cmd,
  output egbp_pkg::egbp_status_t st,
  input  logic                   big_endian,
  input  logic [2:0]             in_action,
  input  logic signed [63:0]     in_value,
  input  logic [6:0]             in_bit_count,
  input  logic [3:0]             in_byte_count,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_byte,
  output logic                   out_last,
  output logic                   out_error
);
  import egbp_pkg::*;

  // item operands
  logic [2:0]  act_r;
  logic [63:0] val_r;
  logic [6:0]  bc_r;
  logic [3:0]  byc_r;
  logic        err_r;
  // ue/se normalizer
  logic [31:0] norm_r;
  logic [4:0]  z_r;
  // bit accumulator and stream state
  logic [ACC_W-1:0] acc_r;
  logic [CNT_W-1:0] total_r;
  logic [7:0]       partial_r;
  logic [2:0]       pos_r;
  // output register
  logic       ov_r;
  logic [7:0] ob_r;
  logic       ol_r;
  logic       oe_r;

  // load-time decode
  logic        in_neg;
  logic [63:0] in_mag;
  logic        in_err;
  logic [31:0] in_code;

  always_comb begin
    in_neg  = in_value[63];
    in_mag  = in_neg ? (64'd0 - 64'(in_value)) : 64'(in_value);
    in_err  = 1'b0;
    in_code = 32'(in_value) + 32'd1;
    case (in_action)
      ACT_BITS:  in_err = (in_bit_count == 7'd0) || (in_bit_count > 7'd64);
      ACT_UE:    in_err = 64'(in_value) > 64'h0000_0000_FFFF_FFFE;
      ACT_SE: begin
        in_err  = in_mag > 64'h0000_0000_7FFF_FFFF;
        // code = 2|v| for v>0, 2|v|+1 for v<=0
        in_code = {in_mag[30:0], in_neg | (in_mag == 64'd0)};
      end
      ACT_BYTES: in_err = !((in_byte_count == 4'd1) || (in_byte_count == 4'd2) ||
                            (in_byte_count == 4'd4) || (in_byte_count == 4'd8));
      ACT_ALIGN: in_err = 1'b0;
      default:   in_err = 1'b1;
    endcase
  end

  // left-aligned bit sequence of the item and its length
  logic [63:0]      seq;
  logic [CNT_W-1:0] seq_len;
  logic [63:0]      rev;
  logic [6:0]       byte_bits;
  logic [6:0]       bits_sh;

  always_comb begin
    rev       = '0;
    byte_bits = {byc_r, 3'b000};
    bits_sh   = 7'd64 - bc_r;
    seq       = '0;
    seq_len   = '0;
    for (int k = 0; k < 8; k++) begin
      rev[63-8*k -: 8] = val_r[8*k +: 8];
    end
    case (act_r)
      ACT_BITS: begin
        seq     = val_r << bits_sh[5:0];
        seq_len = bc_r;
      end
      ACT_UE, ACT_SE: begin
        seq     = {32'd0, norm_r} << ({1'b0, z_r} + 6'd1);
        seq_len = 7'd63 - {1'b0, z_r, 1'b0};
      end
      ACT_BYTES: begin
        if (big_endian) begin
          seq = val_r << (7'd64 - byte_bits);
        end else begin
          seq = rev & ~({64{1'b1}} >> byte_bits);
        end
        seq_len = byte_bits;
      end
      ACT_ALIGN: begin
        seq     = '0;
        seq_len = (pos_r == 3'd0) ? 7'd0 : (7'd8 - {4'd0, pos_r});
      end
      default: begin
        seq     = '0;
        seq_len = '0;
      end
    endcase
  end

  logic slot_free;
  assign slot_free = !ov_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= in_action;
      val_r  <= 64'(in_value);
      bc_r   <= in_bit_count;
      byc_r  <= in_byte_count;
      err_r  <= in_err;
      norm_r <= in_code;
      z_r    <= '0;
    end else if (cmd.norm_step) begin
      if (norm_r[31:28] == 4'd0) begin
        norm_r <= norm_r << 4;
        z_r    <= z_r + 5'd4;
      end else begin
        norm_r <= norm_r << 1;
        z_r    <= z_r + 5'd1;
      end
    end

    if (cmd.build) begin
      acc_r   <= {partial_r, 64'd0} | ({seq, 8'd0} >> pos_r);
      total_r <= {4'd0, pos_r} + seq_len;
    end else if (cmd.emit) begin
      acc_r   <= acc_r << 8;
      total_r <= total_r - 7'd8;
    end

    if (cmd.emit) begin
      ob_r <= acc_r[ACC_W-1 -: 8];
      ol_r <= total_r < 7'd16;
      oe_r <= 1'b0;
    end else if (cmd.err_emit) begin
      ob_r <= 8'd0;
      ol_r <= 1'b1;
      oe_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      pos_r     <= '0;
      ov_r      <= 1'b0;
    end else begin
      if (cmd.commit) begin
        partial_r <= acc_r[ACC_W-1 -: 8];
        pos_r     <= total_r[2:0];
      end
      if (cmd.emit || cmd.err_emit) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign st.err       = err_r;
  assign st.is_code   = (act_r == ACT_UE) || (act_r == ACT_SE);
  assign st.norm_done = norm_r[31];
  assign st.ge8       = total_r >= 7'd8;
  assign st.slot_free = slot_free;

  assign out_valid = ov_r;
  assign out_byte  = ob_r;
  assign out_last  = ol_r;
  assign out_error = oe_r;

`ifndef NO_ASSERTIONS
  a_partial_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (partial_r & (8'hFF >> pos_r)) == 8'd0)
    else $error("unwritten bits of partial byte not zero");
  a_norm_stop: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.norm_step |-> !norm_r[31] && (norm_r != 32'd0))
    else $error("normalizer stepped past its leading one");
  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.err_emit |=> out_valid && out_error && out_last && (out_byte == 8'd0))
    else $error("malformed error word");
  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.build |=> total_r <= 7'd71)
    else $error("accumulator bit count out of range");
`endif

endmodule

>>> hw/rtl/exp_golomb_bit_packer_core.sv
// Channel   Handshake               Payload
// in        in_valid / in_ready     in_action, in_value, in_bit_count, in_byte_count
// out       out_valid / out_ready   out_byte, out_last, out_error
// cfg       psel/penable/pwrite     paddr, pwdata, prdata (pready tied high)
//
// Item steps: load, decode, build, emit full accumulator bytes, commit;
// ue/se also normalize (nibble or single-bit leading-zero steps); an error
// item gives one error word. Bytes leave one per cycle while out_ready is high.
// Reset (rst_n low, synchronous): partial byte cleared, byte aligned, big_endian = 0.
// A stalled out_ready holds the accumulator; the next item is taken once the last
// word of the current one sits in the output register.
module exp_golomb_bit_packer_core (
  input  logic               clk,
  input  logic               rst_n,
  // input words
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_action,
  input  logic signed [63:0] in_value,
  input  logic [6:0]         in_bit_count,
  input  logic [3:0]         in_byte_count,
  // result words
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               out_last,
  output logic               out_error,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import egbp_pkg::*;

  egbp_cmd_t    cmd;
  egbp_status_t st;
  logic         big_endian_r;

  // register file: a single byte-order bit at word 0
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      big_endian_r <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_BIG_ENDIAN)) begin
      big_endian_r <= pwdata[0];
    end
  end

  // reads outside the register map return zero
  assign prdata = (paddr[2] == REG_BIG_ENDIAN) ? {31'd0, big_endian_r} : 32'd0;

  // sequencer: load, decode, normalize (ue/se), build, emit bytes, commit; or error word
  egbp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // operands, normalizer, 72-bit packer accumulator, output register
  egbp_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .big_endian    (big_endian_r),
    .in_action     (in_action),
    .in_value      (in_value),
    .in_bit_count  (in_bit_count),
    .in_byte_count (in_byte_count),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_last      (out_last),
    .out_error     (out_error)
  );

`ifndef NO_ASSERTIONS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled output word changed");
  a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while busy");
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    psel |-> pready)
    else $error("register port stalled");
`endif

endmodule
